// File: rtl/core/gn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_pkg
// Shared types and constants for the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package gn_pkg;

   localparam int GRID_W_DEF = 64;
   localparam int GRID_H_DEF = 64;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int GRAD_W  = 16;
   localparam int IDX_W   = 6;
   localparam int ENTRY_W = 2 * GRAD_W;
   localparam int OFS_W   = FRAC_W + 1;          // offset t or t-1.0, signed
   localparam int DOT_W   = GRAD_W + OFS_W + 1;  // sum of two products
   localparam int DIFF_W  = DOT_W + 1;
   localparam int WT_W    = FRAC_W + 1;          // weight as signed operand
   localparam int PROD_W  = DIFF_W + WT_W;
   localparam int RND_W   = DOT_W - FRAC_W;
   localparam int OUT_W   = 16;
   localparam int SQ_W    = 2 * FRAC_W;
   localparam int CUBE_W  = 3 * FRAC_W;
   localparam int POLY_W  = CUBE_W + 2;

   localparam int SMOOTH_A = 3;
   localparam int SMOOTH_B = 2;

   localparam int NOISE_MAX = 16384;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              col_odd;
      logic              row_odd;
      logic [FRAC_W-1:0] tx;
      logic [FRAC_W-1:0] ty;
   } gn_rd_type;

endpackage

// File: rtl/core/gn_gtable.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_gtable
// Gradient table split in four banks by column and row parity, so the four
// corners of a cell are read at once. Read data and control registered.
// ----------------------------------------------------------------------------
module gn_gtable #(
   parameter int GRID_W = gn_pkg::GRID_W_DEF,
   parameter int GRID_H = gn_pkg::GRID_H_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [gn_pkg::IDX_W-1:0]              wr_col,
   input  logic [gn_pkg::IDX_W-1:0]              wr_row,
   input  logic [gn_pkg::ENTRY_W-1:0]            wr_data,
   input  logic                                  rd_en,
   input  logic [gn_pkg::COORD_W-1:0]            point_x,
   input  logic [gn_pkg::COORD_W-1:0]            point_y,
   output gn_pkg::gn_rd_type                     rd_ctrl,
   output logic [3:0][gn_pkg::ENTRY_W-1:0]       rd_grad
);
   import gn_pkg::*;

   localparam int CW     = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int RW     = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int BCW    = (CW > 1) ? CW - 1 : 1;
   localparam int BRW    = (RW > 1) ? RW - 1 : 1;
   localparam int HALF_W = GRID_W / 2;
   localparam int DEPTH  = (GRID_W / 2) * (GRID_H / 2);
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CW-1:0] wc, c0, c1;
   logic [RW-1:0] wr, r0, r1;
   logic [AW-1:0] waddr;
   logic [1:0]    wbank;
   gn_rd_type     ctrl_ff, ctrl_in;

   assign wc    = CW'(32'(wr_col) % GRID_W);
   assign wr    = RW'(32'(wr_row) % GRID_H);
   assign c0    = CW'(32'(point_x[COORD_W-1:FRAC_W]) % GRID_W);
   assign r0    = RW'(32'(point_y[COORD_W-1:FRAC_W]) % GRID_H);
   assign c1    = CW'((32'(c0) + 32'd1) % GRID_W);
   assign r1    = RW'((32'(r0) + 32'd1) % GRID_H);
   assign wbank = {wr[0], wc[0]};
   assign waddr = AW'(BRW'(wr >> 1)) * AW'(HALF_W) + AW'(BCW'(wc >> 1));

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [ENTRY_W-1:0] mem [DEPTH];
      logic [ENTRY_W-1:0] rdata_ff;
      logic [CW-1:0]      rc;
      logic [RW-1:0]      rr;
      logic [AW-1:0]      raddr;

      // the corner of this bank's parity
      assign rc    = (c0[0] == b[0]) ? c0 : c1;
      assign rr    = (r0[0] == b[1]) ? r0 : r1;
      assign raddr = AW'(BRW'(rr >> 1)) * AW'(HALF_W) + AW'(BCW'(rc >> 1));

      always_ff @(posedge clock) begin
         if (wr_en && (wbank == 2'(b))) begin
            mem[waddr] <= wr_data;
         end
         rdata_ff <= mem[raddr];
      end

      assign rd_grad[b] = rdata_ff;
   end

   always_comb begin
      ctrl_in.valid   = rd_en;
      ctrl_in.col_odd = c0[0];
      ctrl_in.row_odd = r0[0];
      ctrl_in.tx      = point_x[FRAC_W-1:0];
      ctrl_in.ty      = point_y[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.col_odd <= ctrl_in.col_odd;
      ctrl_ff.row_odd <= ctrl_in.row_odd;
      ctrl_ff.tx      <= ctrl_in.tx;
      ctrl_ff.ty      <= ctrl_in.ty;
   end

   assign rd_ctrl = ctrl_ff;

endmodule

// File: rtl/core/gn_smooth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_smooth
// Fade weights s = 3t^2 - 2t^3 in Q0.16 for both axes, three stages.
// ----------------------------------------------------------------------------
module gn_smooth (
   input  logic                        clock,
   input  gn_pkg::gn_rd_type           ctrl,
   output logic [gn_pkg::FRAC_W-1:0]   sx,
   output logic [gn_pkg::FRAC_W-1:0]   sy
);
   import gn_pkg::*;

   logic [FRAC_W-1:0] t_ff  [2];
   logic [SQ_W-1:0]   t2_ff [2];
   logic [SQ_W-1:0]   t2d_ff[2];
   logic [CUBE_W-1:0] t3_ff [2];
   logic [FRAC_W-1:0] s_ff  [2];
   logic [FRAC_W-1:0] t_in  [2];
   logic [POLY_W-1:0] poly  [2];

   assign t_in[0] = ctrl.tx;
   assign t_in[1] = ctrl.ty;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         poly[i] = POLY_W'({t2d_ff[i], {FRAC_W{1'b0}}}) * POLY_W'(SMOOTH_A)
                 - POLY_W'(t3_ff[i]) * POLY_W'(SMOOTH_B);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         t2_ff[i]  <= SQ_W'(t_in[i]) * SQ_W'(t_in[i]);
         t_ff[i]   <= t_in[i];
         t3_ff[i]  <= CUBE_W'(t2_ff[i]) * CUBE_W'(t_ff[i]);
         t2d_ff[i] <= t2_ff[i];
         s_ff[i]   <= poly[i][CUBE_W-1:SQ_W];
      end
   end

   assign sx = s_ff[0];
   assign sy = s_ff[1];

endmodule

// File: rtl/core/gn_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_interp
// Corner dot products, two bilinear blend levels, final rounding and
// saturation to Q1.14.
// ----------------------------------------------------------------------------
module gn_interp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gn_pkg::gn_rd_type                     ctrl,
   input  logic [3:0][gn_pkg::ENTRY_W-1:0]       rd_grad,
   input  logic [gn_pkg::FRAC_W-1:0]             sx,
   input  logic [gn_pkg::FRAC_W-1:0]             sy,
   output logic                                  out_valid,
   output logic signed [gn_pkg::OUT_W-1:0]       out_value
);
   import gn_pkg::*;

   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [DOT_W-1:0]  DOT_HALF  = DOT_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [RND_W-1:0]  SAT_HI    = RND_W'(NOISE_MAX);
   localparam logic signed [RND_W-1:0]  SAT_LO    = -RND_W'(NOISE_MAX);

   // valid pipe, stages 2 to 8
   logic [8:2] v_ff;

   logic signed [GRAD_W-1:0] gx [4];
   logic signed [GRAD_W-1:0] gy [4];
   logic signed [OFS_W-1:0]  dx [4];
   logic signed [OFS_W-1:0]  dy [4];
   logic signed [DOT_W-1:0]  dot_in [4];
   logic signed [DOT_W-1:0]  dot_ff [4];
   logic signed [DOT_W-1:0]  dot3_ff[4];

   logic signed [DIFF_W-1:0] dtop_ff, dbot_ff, d2;
   logic signed [DOT_W-1:0]  lotop_ff, lobot_ff, lotop5_ff, lobot5_ff;
   logic signed [WT_W-1:0]   sx_s, sy_s;
   logic signed [PROD_W-1:0] ptop_ff, pbot_ff, p2_ff, rtop, rbot, r2;
   logic [FRAC_W-1:0]        sy5_ff, sy6_ff;
   logic signed [DOT_W-1:0]  top_ff, bot_ff, top7_ff, v8_ff, v8r;
   logic signed [RND_W-1:0]  fin;
   logic signed [OUT_W-1:0]  out_in, out_ff;
   logic                     out_valid_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         // corner j: bit 0 picks c1, bit 1 picks r1
         gx[j] = rd_grad[{ctrl.row_odd ^ j[1], ctrl.col_odd ^ j[0]}][GRAD_W-1:0];
         gy[j] = rd_grad[{ctrl.row_odd ^ j[1], ctrl.col_odd ^ j[0]}][ENTRY_W-1:GRAD_W];
         dx[j] = {j[0] == 1'b1, ctrl.tx};
         dy[j] = {j[1] == 1'b1, ctrl.ty};
         dot_in[j] = DOT_W'(gx[j]) * DOT_W'(dx[j]) + DOT_W'(gy[j]) * DOT_W'(dy[j]);
      end
   end

   assign sx_s = {1'b0, sx};
   assign sy_s = {1'b0, sy6_ff};
   assign rtop = ptop_ff + PROD_HALF;
   assign rbot = pbot_ff + PROD_HALF;
   assign d2   = DIFF_W'(bot_ff) - DIFF_W'(top_ff);
   assign r2   = p2_ff + PROD_HALF;
   assign v8r  = v8_ff + DOT_HALF;
   assign fin  = RND_W'(v8r >>> FRAC_W);

   always_comb begin
      if (fin > SAT_HI) begin
         out_in = OUT_W'(SAT_HI);
      end else if (fin < SAT_LO) begin
         out_in = OUT_W'(SAT_LO);
      end else begin
         out_in = OUT_W'(fin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         v_ff         <= {v_ff[7:2], ctrl.valid};
         out_valid_ff <= v_ff[8];
      end
      for (int j = 0; j < 4; j++) begin
         dot_ff[j]  <= dot_in[j];
         dot3_ff[j] <= dot_ff[j];
      end
      dtop_ff   <= DIFF_W'(dot3_ff[1]) - DIFF_W'(dot3_ff[0]);
      dbot_ff   <= DIFF_W'(dot3_ff[3]) - DIFF_W'(dot3_ff[2]);
      lotop_ff  <= dot3_ff[0];
      lobot_ff  <= dot3_ff[2];
      ptop_ff   <= PROD_W'(dtop_ff) * PROD_W'(sx_s);
      pbot_ff   <= PROD_W'(dbot_ff) * PROD_W'(sx_s);
      lotop5_ff <= lotop_ff;
      lobot5_ff <= lobot_ff;
      sy5_ff    <= sy;
      top_ff    <= lotop5_ff + DOT_W'(rtop >>> FRAC_W);
      bot_ff    <= lobot5_ff + DOT_W'(rbot >>> FRAC_W);
      sy6_ff    <= sy5_ff;
      p2_ff     <= PROD_W'(d2) * PROD_W'(sy_s);
      top7_ff   <= top_ff;
      v8_ff     <= top7_ff + DOT_W'(r2 >>> FRAC_W);
      out_ff    <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_ff;

   a_out_range: assert property (@(posedge clock)
      out_valid |-> (out_value <= OUT_W'(NOISE_MAX)) && (out_value >= -OUT_W'(NOISE_MAX)))
      else $error("noise word out of range");

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      ctrl.valid |-> ##8 out_valid)
      else $error("evaluate word lost in pipeline");

   a_latency_bwd: assert property (@(posedge clock)
      out_valid |-> $past(ctrl.valid, 8))
      else $error("result word without evaluate word");

endmodule

// File: rtl/core/gradient_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise: four-bank gradient table, fade weights, bilinear blend.
// ----------------------------------------------------------------------------
// The result strobe rises once the word has passed the table read registers and the gn_interp pipe.
// Throughput: one word per cycle; the four parity banks give all corners at once.
// busy stays low: the pipeline never stalls since the receiver cannot.
// Reset clears only the valid pipe; table contents are undefined until written.
module gradient_noise_2d #(
   parameter int GRID_W = gn_pkg::GRID_W_DEF,
   parameter int GRID_H = gn_pkg::GRID_H_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [gn_pkg::IDX_W-1:0]           req_entry_col,
   input  logic [gn_pkg::IDX_W-1:0]           req_entry_row,
   input  logic signed [gn_pkg::GRAD_W-1:0]   req_grad_x,
   input  logic signed [gn_pkg::GRAD_W-1:0]   req_grad_y,
   input  logic [gn_pkg::COORD_W-1:0]         req_point_x,
   input  logic [gn_pkg::COORD_W-1:0]         req_point_y,
   output logic                               rsp_valid,
   output logic signed [gn_pkg::OUT_W-1:0]    rsp_noise_value
);
   import gn_pkg::*;

   logic                          accept;
   gn_rd_type                     rd_ctrl;
   logic [3:0][ENTRY_W-1:0]       rd_grad;
   logic [FRAC_W-1:0]             sx, sy;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   gn_gtable #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_gtable (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (req_operation == OP_WRITE)),
      .wr_col  (req_entry_col),
      .wr_row  (req_entry_row),
      .wr_data ({req_grad_y, req_grad_x}),
      .rd_en   (accept && (req_operation == OP_EVAL)),
      .point_x (req_point_x),
      .point_y (req_point_y),
      .rd_ctrl (rd_ctrl),
      .rd_grad (rd_grad)
   );

   gn_smooth u_smooth (
      .clock (clock),
      .ctrl  (rd_ctrl),
      .sx    (sx),
      .sy    (sy)
   );

   gn_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (rd_ctrl),
      .rd_grad   (rd_grad),
      .sx        (sx),
      .sy        (sy),
      .out_valid (rsp_valid),
      .out_value (rsp_noise_value)
   );

endmodule

// File: tb/tb_gradient_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Self-checking bench: loads gradients, evaluates points and checks each noise
// word against a bit-exact in-bench predictor.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;
   import gn_pkg::*;

   localparam int GW         = GRID_W_DEF;
   localparam int GH         = GRID_H_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int NUM_ITEMS  = 450;

   typedef struct {
      logic                     op;
      logic [IDX_W-1:0]         col;
      logic [IDX_W-1:0]         row;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic [COORD_W-1:0]       px;
      logic [COORD_W-1:0]       py;
   } noise_cmd_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_operation = OP_WRITE;
   logic [IDX_W-1:0]          req_entry_col = '0;
   logic [IDX_W-1:0]          req_entry_row = '0;
   logic signed [GRAD_W-1:0]  req_grad_x = '0;
   logic signed [GRAD_W-1:0]  req_grad_y = '0;
   logic [COORD_W-1:0]        req_point_x = '0;
   logic [COORD_W-1:0]        req_point_y = '0;
   logic                      rsp_valid;
   logic signed [OUT_W-1:0]   rsp_noise_value;

   noise_cmd_type             cmd_q[$];
   logic signed [OUT_W-1:0]   noise_exp_q[$];
   logic [ENTRY_W-1:0]        grad_model[GW*GH];
   bit                        loaded[GW*GH];
   int                        errors = 0;
   int                        gap_left = 0;
   int                        idle_cycles = 0;
   bit                        burst = 1'b0;

   gradient_noise_2d dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_entry_col(req_entry_col),
      .req_entry_row(req_entry_row), .req_grad_x(req_grad_x),
      .req_grad_y(req_grad_y), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .rsp_valid(rsp_valid),
      .rsp_noise_value(rsp_noise_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // ---- predictor -----------------------------------------------------------
   function automatic longint rshift_round(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint fade(input longint unsigned t);
      longint unsigned a, b;
      a = SMOOTH_A * t * t * 65536;
      b = SMOOTH_B * t * t * t;
      return longint'((a - b) >> 32);
   endfunction

   function automatic longint lerp(input longint lo, input longint hi, input longint s);
      return rshift_round(lo * (65536 - s) + hi * s, 16);
   endfunction

   function automatic longint dot_corner(input int c, input int r,
                                         input longint dx, input longint dy);
      logic [ENTRY_W-1:0] e;
      longint gx, gy;
      e  = grad_model[r * GW + c];
      gx = $signed(e[15:0]);
      gy = $signed(e[31:16]);
      return gx * dx + gy * dy;
   endfunction

   function automatic logic signed [OUT_W-1:0] noise_at(input logic [COORD_W-1:0] px,
                                                        input logic [COORD_W-1:0] py);
      int c0, c1, r0, r1;
      longint tx, ty, sx, sy, top, bot, v;
      c0 = px[31:16] % GW;
      r0 = py[31:16] % GH;
      c1 = (c0 + 1) % GW;
      r1 = (r0 + 1) % GH;
      tx = px[15:0];
      ty = py[15:0];
      sx = fade(tx);
      sy = fade(ty);
      top = lerp(dot_corner(c0, r0, tx, ty), dot_corner(c1, r0, tx - 65536, ty), sx);
      bot = lerp(dot_corner(c0, r1, tx, ty - 65536),
                 dot_corner(c1, r1, tx - 65536, ty - 65536), sx);
      v = rshift_round(lerp(top, bot, sy), 16);
      if (v > NOISE_MAX) v = NOISE_MAX;
      if (v < -NOISE_MAX) v = -NOISE_MAX;
      return v[OUT_W-1:0];
   endfunction

   // ---- stimulus builders ---------------------------------------------------
   function automatic logic [GRAD_W-1:0] rand_grad();
      if ($urandom_range(0, 9) == 0) return GRAD_W'($urandom());
      return GRAD_W'($urandom_range(0, 2 * NOISE_MAX) - NOISE_MAX);
   endfunction

   task automatic push_write(input int c, input int r,
                             input logic [GRAD_W-1:0] gx, input logic [GRAD_W-1:0] gy);
      noise_cmd_type w;
      w = '{OP_WRITE, c[IDX_W-1:0], r[IDX_W-1:0], gx, gy, $urandom(), $urandom()};
      loaded[r * GW + c] = 1'b1;
      cmd_q.push_back(w);
   endtask

   // corners must be loaded before a point may read them
   task automatic push_eval(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      noise_cmd_type e;
      int c0, r0, c, r;
      c0 = px[31:16] % GW;
      r0 = py[31:16] % GH;
      for (int i = 0; i < 4; i++) begin
         c = (c0 + i % 2) % GW;
         r = (r0 + i / 2) % GH;
         if (!loaded[r * GW + c]) push_write(c, r, rand_grad(), rand_grad());
      end
      e = '{OP_EVAL, IDX_W'($urandom()), IDX_W'($urandom()),
            GRAD_W'($urandom()), GRAD_W'($urandom()), px, py};
      cmd_q.push_back(e);
   endtask

   // ---- driver --------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         idle_cycles <= 0;
         if (req_operation == OP_WRITE)
            grad_model[int'(req_entry_row) * GW + int'(req_entry_col)] =
               {req_grad_y, req_grad_x};
         else
            noise_exp_q.push_back(noise_at(req_point_x, req_point_y));
         void'(cmd_q.pop_front());
         if ($urandom_range(0, 15) == 0) burst = !burst;
         gap_left = burst ? 0 : $urandom_range(0, 17);
      end else if (rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset || cmd_q.size() == 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         start <= 1'b0;
      end else begin
         start         <= 1'b1;
         req_operation <= cmd_q[0].op;
         req_entry_col <= cmd_q[0].col;
         req_entry_row <= cmd_q[0].row;
         req_grad_x    <= cmd_q[0].gx;
         req_grad_y    <= cmd_q[0].gy;
         req_point_x   <= cmd_q[0].px;
         req_point_y   <= cmd_q[0].py;
      end
   end

   // ---- monitor -------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (noise_exp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected noise word %0d", rsp_noise_value));
         end else begin
            if (rsp_noise_value !== noise_exp_q[0])
               report_mismatch($sformatf("noise_value got %0d want %0d",
                                         rsp_noise_value, noise_exp_q[0]));
            void'(noise_exp_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("gradient_noise_2d regression: fail");
         $finish;
      end
   end

   // ---- sequence ------------------------------------------------------------
   initial begin
      // directed: wrap corners, extreme gradients and points, saturation
      push_write(0, 0, 16'sd16384, 16'sd16384);
      push_write(GW - 1, 0, -16'sd16384, 16'sd16384);
      push_write(0, GH - 1, 16'sd16384, -16'sd16384);
      push_write(GW - 1, GH - 1, -16'sd16384, -16'sd16384);
      push_eval(32'h0000_0000, 32'h0000_0000);
      push_eval(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_eval(32'h003F_8000, 32'h003F_8000);
      push_eval(32'h0000_FFFF, 32'h0000_0001);
      push_eval(32'h0040_0000, 32'hFFC0_8000);
      push_write(10, 10, 16'h7FFF, 16'h7FFF);
      push_write(11, 10, 16'h8000, 16'h7FFF);
      push_write(10, 11, 16'h7FFF, 16'h8000);
      push_write(11, 11, 16'h8000, 16'h8000);
      push_eval(32'h000A_8000, 32'h000A_8000);
      push_eval(32'h000A_4000, 32'h000A_C000);
      push_write(20, 20, 16'h8000, 16'h8000);
      push_write(21, 20, 16'h7FFF, 16'h8000);
      push_write(20, 21, 16'h8000, 16'h7FFF);
      push_write(21, 21, 16'h7FFF, 16'h7FFF);
      push_eval(32'h0014_8000, 32'h0014_8000);
      push_eval(32'h0014_0000, 32'h0014_FFFF);
      // random mix of loads and evaluations, corner loads included in the count
      while (cmd_q.size() < NUM_ITEMS) begin
         if ($urandom_range(0, 9) < 4)
            push_write($urandom_range(0, GW - 1), $urandom_range(0, GH - 1),
                       rand_grad(), rand_grad());
         else
            push_eval($urandom(), $urandom());
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (cmd_q.size() != 0 || noise_exp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("gradient_noise_2d regression: pass");
      else
         $display("gradient_noise_2d regression: fail");
      $finish;
   end

endmodule
